### hdl/fnq_pkg.sv
// ----------------------------------------------------------------------------
// fnq_pkg: shared types, constants and the mod12 function of the note quantizer
// Holds the fixed-point sizes, the status codes and the beat carried along
// the log2 cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnq_pkg;

    // Octaves on each side of the reference; a note is reported up to half a semitone inside it.
    localparam int OCTAVE_SPAN   = 10;
    // Fractional bits of the fixed-point log2, one squaring cell per bit.
    localparam int LOG_FRAC_BITS = 16;

    // log2 word: 5 integer bits (bit position 0..31) and the fraction.
    localparam int L_W = 5 + LOG_FRAC_BITS;
    // Signed log2 difference.
    localparam int D_W = L_W + 1;
    // 24 times the magnitude of the difference.
    localparam int T_W = L_W + 5;
    // Magnitude of the semitone count and its signed form.
    localparam int M_W = $clog2(12 * OCTAVE_SPAN + 1);
    localparam int K_W = M_W + 1;
    // Signed working width of the offset remainder.
    localparam int S_W = D_W + 6;

    localparam logic [31:0] REF_RESET = 32'd28835840;

    typedef enum logic [1:0] {
        ST_NOTE     = 2'd0,
        ST_NO_PITCH = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // One beat of the log2 chain: both mantissas travel together so the
    // reference log is always taken from the value seen at entry.
    typedef struct packed {
        logic                     zero;
        logic [4:0]               pos_f;
        logic [4:0]               pos_r;
        logic [31:0]              mant_f;
        logic [31:0]              mant_r;
        logic [LOG_FRAC_BITS-1:0] frac_f;
        logic [LOG_FRAC_BITS-1:0] frac_r;
    } t_log_beat;

    // Remainder modulo 12 of a value below 256, by reciprocal multiply.
    function automatic logic [3:0] mod12(input logic [7:0] val);
        logic [15:0] prod;
        logic [4:0]  quo;
        logic [7:0]  rem;
        prod = 16'(val) * 16'd171;
        quo  = prod[15:11];
        rem  = val - 8'({3'b000, quo} * 8'd12);
        return rem[3:0];
    endfunction

endpackage

### hdl/fnq_norm.sv
// ----------------------------------------------------------------------------
// fnq_norm: leading-one search and mantissa normalization
// Finds the integer part of log2 for the frequency and the reference and
// shifts both to a Q1.31 mantissa.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnq_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_freq_hz,
    input  logic [31:0]        i_ref_freq,
    input  logic               i_down_ready,
    output logic               o_ready,
    output logic               o_valid,
    output fnq_pkg::t_log_beat o_beat
);

    logic               r_valid;
    fnq_pkg::t_log_beat r_beat;
    fnq_pkg::t_log_beat n_beat;
    logic [31:0]        ref_val;
    logic [4:0]         pos_f;
    logic [4:0]         pos_r;

    // A zero reference is taken as the smallest legal value.
    assign ref_val = (i_ref_freq == 32'd0) ? 32'd1 : i_ref_freq;

    always_comb begin
        pos_f = 5'd0;
        pos_r = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_freq_hz[i]) begin
                pos_f = 5'(i);
            end
            if (ref_val[i]) begin
                pos_r = 5'(i);
            end
        end
        n_beat.zero   = (i_freq_hz == 32'd0);
        n_beat.pos_f  = pos_f;
        n_beat.pos_r  = pos_r;
        n_beat.mant_f = i_freq_hz << (5'd31 - pos_f);
        n_beat.mant_r = ref_val << (5'd31 - pos_r);
        n_beat.frac_f = '0;
        n_beat.frac_r = '0;
    end

    assign o_ready = !r_valid || i_down_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### hdl/fnq_sq_cell.sv
// ----------------------------------------------------------------------------
// fnq_sq_cell: one squaring cell of the log2 chain
// Squares both mantissas once and shifts one fraction bit into each log.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnq_sq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fnq_pkg::t_log_beat i_beat,
    input  logic               i_down_ready,
    output logic               o_ready,
    output logic               o_valid,
    output fnq_pkg::t_log_beat o_beat
);

    logic               r_valid;
    fnq_pkg::t_log_beat r_beat;
    fnq_pkg::t_log_beat n_beat;
    logic [63:0]        prod_f;
    logic [63:0]        prod_r;
    logic [32:0]        sq_f;
    logic [32:0]        sq_r;

    assign prod_f = 64'(i_beat.mant_f) * 64'(i_beat.mant_f);
    assign prod_r = 64'(i_beat.mant_r) * 64'(i_beat.mant_r);
    assign sq_f   = prod_f[63:31];
    assign sq_r   = prod_r[63:31];

    // A square of 2.0 or more yields a one bit and is halved back into range.
    always_comb begin
        n_beat        = i_beat;
        n_beat.mant_f = sq_f[32] ? sq_f[32:1] : sq_f[31:0];
        n_beat.mant_r = sq_r[32] ? sq_r[32:1] : sq_r[31:0];
        n_beat.frac_f = {i_beat.frac_f[fnq_pkg::LOG_FRAC_BITS-2:0], sq_f[32]};
        n_beat.frac_r = {i_beat.frac_r[fnq_pkg::LOG_FRAC_BITS-2:0], sq_r[32]};
    end

    assign o_ready = !r_valid || i_down_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### hdl/fnq_quant.sv
// ----------------------------------------------------------------------------
// fnq_quant: cent quantizer and result register
// Turns the two logs into the nearest semitone, note name and tuning offset
// over three registered stages, the last one being the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnq_quant (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fnq_pkg::t_log_beat i_beat,
    input  logic               i_down_ready,
    output logic               o_ready,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [3:0]         o_note_index,
    output logic signed [7:0]  o_semitone_count,
    output logic [8:0]         o_offset_frac
);

    localparam int F = fnq_pkg::LOG_FRAC_BITS;
    localparam logic [fnq_pkg::T_W-1:0] OOR_LIM =
        fnq_pkg::T_W'(24 * fnq_pkg::OCTAVE_SPAN - 1) << F;
    localparam logic [fnq_pkg::T_W:0] HALF_UP = (fnq_pkg::T_W + 1)'((2 ** F) - 1);

    typedef struct packed {
        logic                            zero;
        logic                            neg;
        logic signed [fnq_pkg::D_W-1:0]  diff;
        logic [fnq_pkg::L_W-1:0]         mag;
    } t_diff_beat;

    typedef struct packed {
        logic                            zero;
        logic                            neg;
        logic                            oor;
        logic signed [fnq_pkg::D_W-1:0]  diff;
        logic [fnq_pkg::M_W-1:0]         semis;
    } t_round_beat;

    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    t_diff_beat       r_s1;
    t_diff_beat       n_s1;
    t_round_beat      r_s2;
    t_round_beat      n_s2;

    logic                            r_zero;
    logic                            r_oor;
    logic [3:0]                      r_note;
    logic signed [7:0]               r_count;
    logic [8:0]                      r_off;
    logic [3:0]                      n_note;
    logic signed [7:0]               n_count;
    logic [8:0]                      n_off;

    logic [fnq_pkg::L_W-1:0]         log_f;
    logic [fnq_pkg::L_W-1:0]         log_r;
    logic [fnq_pkg::T_W-1:0]         mag24;
    logic [fnq_pkg::T_W:0]           round_sum;
    logic signed [fnq_pkg::K_W-1:0]  count_k;
    logic signed [fnq_pkg::S_W-1:0]  rem_s;
    logic [F+1:0]                    rem_u;
    logic [F+9:0]                    off_sum;
    logic [3:0]                      mod_r;

    assign rdy3    = !r_v3 || i_down_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Stage 1: signed log difference and its magnitude.
    always_comb begin
        log_f       = {i_beat.pos_f, i_beat.frac_f};
        log_r       = {i_beat.pos_r, i_beat.frac_r};
        n_s1.zero   = i_beat.zero;
        n_s1.diff   = $signed({1'b0, log_f}) - $signed({1'b0, log_r});
        n_s1.neg    = n_s1.diff[fnq_pkg::D_W-1];
        n_s1.mag    = n_s1.neg ? fnq_pkg::L_W'(-n_s1.diff) : fnq_pkg::L_W'(n_s1.diff);
    end

    // Stage 2: cents are 1200 times the difference, so with everything divided
    // by 50 the nearest semitone is (24|d| + 2^F - 1) >> (F + 1), which also
    // rounds a tie toward the smaller magnitude.
    always_comb begin
        mag24      = (fnq_pkg::T_W'(r_s1.mag) << 4) + (fnq_pkg::T_W'(r_s1.mag) << 3);
        round_sum  = (fnq_pkg::T_W + 1)'(mag24) + HALF_UP;
        n_s2.zero  = r_s1.zero;
        n_s2.neg   = r_s1.neg;
        n_s2.oor   = (mag24 > OOR_LIM);
        n_s2.diff  = r_s1.diff;
        n_s2.semis = fnq_pkg::M_W'(round_sum >> (F + 1));
    end

    // Stage 3: the remainder 24d - 2k*2^F + 2^F lies in 0..2^(F+1); the
    // offset is that scaled to 256 with rounding half up.
    always_comb begin
        count_k = r_s2.neg ? -$signed({1'b0, r_s2.semis}) : $signed({1'b0, r_s2.semis});
        rem_s   = (fnq_pkg::S_W'(r_s2.diff) <<< 4) + (fnq_pkg::S_W'(r_s2.diff) <<< 3)
                - (fnq_pkg::S_W'(count_k) <<< (F + 1)) + fnq_pkg::S_W'(2 ** F);
        rem_u   = rem_s[F+1:0];
        off_sum = {rem_u, 8'h00} + (F + 10)'(2 ** F);
        n_off   = off_sum[F+9:F+1];
        mod_r   = fnq_pkg::mod12(8'(r_s2.semis));
        n_note  = (r_s2.neg && (mod_r != 4'd0)) ? 4'd12 - mod_r : mod_r;
        n_count = 8'(count_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_v2) begin
            r_zero  <= r_s2.zero;
            r_oor   <= r_s2.oor;
            r_note  <= n_note;
            r_count <= n_count;
            r_off   <= n_off;
        end
    end

    always_comb begin
        priority if (r_zero) begin
            o_status         = fnq_pkg::ST_NO_PITCH;
            o_note_index     = 4'd0;
            o_semitone_count = 8'sd0;
            o_offset_frac    = 9'd128;
        end else if (r_oor) begin
            o_status         = fnq_pkg::ST_RANGE;
            o_note_index     = 4'd0;
            o_semitone_count = 8'sd0;
            o_offset_frac    = 9'd0;
        end else begin
            o_status         = fnq_pkg::ST_NOTE;
            o_note_index     = r_note;
            o_semitone_count = r_count;
            o_offset_frac    = r_off;
        end
    end

    assign o_valid = r_v3;

endmodule

### hdl/frequency_to_note_quantizer.sv
// ----------------------------------------------------------------------------
// frequency_to_note_quantizer: nearest equal-tempered note of a frequency
// Pipeline: a normalize stage, one squaring cell per log2 fraction bit, two
//   quantizer stages and the output register.
// Throughput: one beat per cycle while the output is not stalled; stages
//   with no beat fill even under stall.
// Reset: synchronous, active low; empties the pipeline, reference is 440 Hz.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frequency_to_note_quantizer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [31:0]       i_freq_hz,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [3:0]        o_note_index,
    output logic signed [7:0] o_semitone_count,
    output logic [8:0]        o_offset_frac,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);

    localparam int F = fnq_pkg::LOG_FRAC_BITS;

    logic               [31:0] r_ref_freq;
    logic                      norm_ready;
    fnq_pkg::t_log_beat        chain_beat  [0:F];
    logic                      chain_valid [0:F];
    logic                      chain_ready [0:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq <= fnq_pkg::REF_RESET;
        end else if (i_cfg_we) begin
            r_ref_freq <= i_cfg_wdata;
        end
    end

    fnq_norm u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_freq_hz    (i_freq_hz),
        .i_ref_freq   (r_ref_freq),
        .i_down_ready (chain_ready[0]),
        .o_ready      (norm_ready),
        .o_valid      (chain_valid[0]),
        .o_beat       (chain_beat[0])
    );

    for (genvar g = 0; g < F; g++) begin : g_cell
        fnq_sq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (chain_valid[g]),
            .i_beat       (chain_beat[g]),
            .i_down_ready (chain_ready[g+1]),
            .o_ready      (chain_ready[g]),
            .o_valid      (chain_valid[g+1]),
            .o_beat       (chain_beat[g+1])
        );
    end

    fnq_quant u_quant (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (chain_valid[F]),
        .i_beat           (chain_beat[F]),
        .i_down_ready     (!i_out_stall),
        .o_ready          (chain_ready[F]),
        .o_valid          (o_out_valid),
        .o_status         (o_status),
        .o_note_index     (o_note_index),
        .o_semitone_count (o_semitone_count),
        .o_offset_frac    (o_offset_frac)
    );

    assign o_in_stall = !norm_ready;

    // With the output register empty every stage can move, so input never stalls.
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while the output register is empty");

    a_note_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == fnq_pkg::ST_NOTE))
        |-> ((o_note_index < 4'd12) && (o_offset_frac <= 9'd256)))
        else $error("note index or offset out of range");

    a_special_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != fnq_pkg::ST_NOTE))
        |-> ((o_note_index == 4'd0) && (o_semitone_count == 8'sd0)))
        else $error("note fields not cleared for a special status");

    a_note_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == fnq_pkg::ST_NOTE) && (o_semitone_count == 8'sd0))
        |-> (o_note_index == 4'd0))
        else $error("zero semitone count must name the reference note");

endmodule

### tb/sv/tb_frequency_to_note_quantizer.sv
// ----------------------------------------------------------------------------
// tb_frequency_to_note_quantizer: regression bench for the note quantizer
// A queue-fed driver sends frequencies with random gaps, and a sink stalls at
// random. Every accepted frequency is run through a bit-exact local model of
// the log2, cent and rounding arithmetic. Result beats are then checked field
// by field, in order. The reference pitch is rewritten between phases while
// the pipeline is empty, including both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frequency_to_note_quantizer;

    localparam int HALF_PERIOD  = 4;
    localparam int PIPE_LATENCY = fnq_pkg::LOG_FRAC_BITS + 4;
    localparam int STALL_LIMIT  = 1000;

    typedef struct {
        fnq_pkg::t_status   status;
        logic [3:0]         note;
        logic signed [7:0]  count;
        logic [8:0]         offset;
    } t_note_result;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    logic [31:0]       i_freq_hz        = 32'd0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b0;
    logic [1:0]        o_status;
    logic [3:0]        o_note_index;
    logic signed [7:0] o_semitone_count;
    logic [8:0]        o_offset_frac;
    logic              i_cfg_we         = 1'b0;
    logic [31:0]       i_cfg_wdata      = 32'd0;

    logic [31:0]  ref_model = fnq_pkg::REF_RESET;
    logic [31:0]  pending_freq_q[$];
    t_note_result note_expect_q[$];

    bit in_taken    = 1'b0;
    bit out_taken   = 1'b0;
    int idle_cycles = 0;
    int errors      = 0;

    frequency_to_note_quantizer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_freq_hz        (i_freq_hz),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_note_index     (o_note_index),
        .o_semitone_count (o_semitone_count),
        .o_offset_frac    (o_offset_frac),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int msb_pos(input logic [31:0] x);
        int pos;
        pos = 0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) pos = i;
        end
        return pos;
    endfunction

    // Integer part is the leading-one position; each fraction bit comes from
    // squaring the Q1.31 mantissa and renormalizing when it reaches 2.
    function automatic logic [63:0] fixed_log2(input logic [31:0] x);
        int          pos;
        logic [63:0] mant;
        logic [63:0] frac;
        pos  = msb_pos(x);
        mant = 64'(x) << (31 - pos);
        frac = 64'd0;
        for (int i = 0; i < fnq_pkg::LOG_FRAC_BITS; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000) begin
                mant = mant >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(pos) << fnq_pkg::LOG_FRAC_BITS) | frac;
    endfunction

    function automatic t_note_result predict_note(input logic [31:0] freq,
                                                  input logic [31:0] refv);
        t_note_result res;
        logic [31:0]  r;
        longint       one, d, c, u, m, k, rem, off;
        one = longint'(1) << fnq_pkg::LOG_FRAC_BITS;
        r   = (refv == 32'd0) ? 32'd1 : refv;
        res.status = fnq_pkg::ST_NOTE;
        res.note   = 4'd0;
        res.count  = 8'sd0;
        res.offset = 9'd0;
        if (freq == 32'd0) begin
            res.status = fnq_pkg::ST_NO_PITCH;
            res.offset = 9'd128;
            return res;
        end
        d = longint'(fixed_log2(freq)) - longint'(fixed_log2(r));
        c = 1200 * d;
        u = (c < 0) ? -c : c;
        if (u > longint'(1200 * fnq_pkg::OCTAVE_SPAN - 50) * one) begin
            res.status = fnq_pkg::ST_RANGE;
            return res;
        end
        // Rounding the magnitude up past the half-step keeps ties small.
        if (u <= 50 * one) m = 0;
        else m = (u - 50 * one + 100 * one - 1) / (100 * one);
        k   = (c < 0) ? -m : m;
        rem = c - 100 * k * one + 50 * one;
        off = (rem * 256 + 50 * one) / (100 * one);
        res.note   = 4'(((k % 12) + 12) % 12);
        res.count  = 8'(k);
        res.offset = 9'(off);
        return res;
    endfunction

    // Mostly frequencies within eleven octaves of the reference, plus silence,
    // exact octave multiples and fully random words.
    function automatic logic [31:0] draw_freq(input logic [31:0] refv);
        int          sel, pos, sh;
        logic [31:0] lead;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 32'd0;
        if (sel <= 2) return $urandom;
        if (sel == 3) begin
            sh = $urandom_range(0, 18) - 9;
            return (sh >= 0) ? (refv << sh) : (refv >> (-sh));
        end
        pos = msb_pos(refv) + $urandom_range(0, 22) - 11;
        if (pos < 0) pos = 0;
        if (pos > 31) pos = 31;
        lead = 32'd1 << pos;
        return lead | ($urandom & (lead - 32'd1));
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // A beat popped by the driver on the same edge only shows up later, so the
    // drain is checked once more after a further wait.
    task automatic wait_idle();
        bit busy;
        busy = 1'b1;
        while (busy) begin
            while (pending_freq_q.size() != 0 || i_in_valid || note_expect_q.size() != 0)
                @(negedge i_clk);
            repeat (4) @(negedge i_clk);
            busy = (pending_freq_q.size() != 0) || i_in_valid || (note_expect_q.size() != 0);
        end
    endtask

    task automatic set_reference(input logic [31:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        ref_model    = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) pending_freq_q.push_back(draw_freq(ref_model));
    endtask

    // Sender: holds a beat until it is taken, then waits its drawn gap.
    always @(negedge i_clk) begin : driver
        int gap_left;
        bit calm;
        bit next_valid;
        if (!i_rst_n) begin
            gap_left = 0;
            calm     = 1'b0;
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid && !in_taken;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_freq_q.size() > 0) begin
                    next_valid = 1'b1;
                    i_freq_hz <= pending_freq_q.pop_front();
                    if ($urandom_range(0, 39) == 0) calm = !calm;
                    gap_left = calm ? 0 : $urandom_range(0, 12);
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Receiver: after each result beat, stalls for a drawn number of cycles.
    always @(negedge i_clk) begin : sink
        int stall_left;
        bit calm;
        if (!i_rst_n) begin
            stall_left = 0;
            calm       = 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (out_taken) begin
                if ($urandom_range(0, 39) == 0) calm = !calm;
                stall_left = calm ? 0 : $urandom_range(0, 12);
            end
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_note_result want;
        if (!i_rst_n) begin
            in_taken    = 1'b0;
            out_taken   = 1'b0;
            idle_cycles = 0;
        end else begin
            in_taken  = i_in_valid && !o_in_stall;
            out_taken = o_out_valid && !i_out_stall;
            if (out_taken) begin
                if (note_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none got status %0d",
                             $time, o_status);
                end else begin
                    want = note_expect_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("note_index", want.note, o_note_index);
                    check_field("semitone_count", want.count, o_semitone_count);
                    check_field("offset_frac", want.offset, o_offset_frac);
                end
            end
            if (in_taken) note_expect_q.push_back(predict_note(i_freq_hz, ref_model));
            if (in_taken || out_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                    $display("frequency_to_note_quantizer regression: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset reference of 440 Hz: silence, octaves, semitone neighbors
        // and the word extremes.
        pending_freq_q.push_back(32'd0);
        pending_freq_q.push_back(fnq_pkg::REF_RESET);
        pending_freq_q.push_back(fnq_pkg::REF_RESET << 1);
        pending_freq_q.push_back(fnq_pkg::REF_RESET >> 1);
        pending_freq_q.push_back(fnq_pkg::REF_RESET << 7);
        pending_freq_q.push_back(fnq_pkg::REF_RESET >> 9);
        pending_freq_q.push_back(fnq_pkg::REF_RESET + 32'd1);
        pending_freq_q.push_back(fnq_pkg::REF_RESET - 32'd1);
        pending_freq_q.push_back(32'd30541696);
        pending_freq_q.push_back(32'd29681008);
        pending_freq_q.push_back(32'd1);
        pending_freq_q.push_back(32'hFFFF_FFFF);
        pending_freq_q.push_back(32'h8000_0000);
        pending_freq_q.push_back(32'h0000_FFFF);
        queue_random(100);

        // 1 Hz reference: exactly ten octaves is already out of range.
        set_reference(32'h0001_0000);
        pending_freq_q.push_back(32'h0400_0000);
        pending_freq_q.push_back(32'h03FF_FFFF);
        pending_freq_q.push_back(32'h0200_0000);
        pending_freq_q.push_back(32'h0000_0040);
        pending_freq_q.push_back(32'h0000_0080);
        queue_random(120);

        set_reference(32'd1);
        pending_freq_q.push_back(32'd1);
        pending_freq_q.push_back(32'd2);
        pending_freq_q.push_back(32'h0000_0400);
        queue_random(80);

        set_reference(32'hFFFF_FFFF);
        pending_freq_q.push_back(32'hFFFF_FFFF);
        pending_freq_q.push_back(32'h7FFF_FFFF);
        pending_freq_q.push_back(32'd1);
        queue_random(80);

        repeat (4) begin
            if ($urandom_range(0, 1) == 0)
                set_reference($urandom_range(32'd20 << 16, 32'd5000 << 16));
            else
                set_reference($urandom | 32'd1);
            queue_random(100);
        end

        set_reference(fnq_pkg::REF_RESET);
        queue_random(120);

        wait_idle();
        repeat (2 * PIPE_LATENCY) @(negedge i_clk);
        if (errors == 0) begin
            $display("frequency_to_note_quantizer regression: pass");
        end else begin
            $display("frequency_to_note_quantizer regression: fail");
        end
        $finish;
    end

endmodule
